[rtl/core/ssb_pkg.sv]
// shared types and constants of the screen strip binner
package ssb_pkg;

    // fixed field widths
    localparam int COORD_W  = 16;
    localparam int PRIM_W   = 16;
    localparam int SIZE_W   = 13;
    localparam int CNT_W    = 5;
    localparam int SID_W    = 4;
    localparam int SLOT_W   = 12;
    localparam int CIDX_W   = 2;
    localparam int ID_LIMIT = 16;

    // span divider: one quotient bit per cycle
    localparam int DIV_STEPS = SIZE_W;
    localparam int DIV_CW    = 4;

    // input operation codes
    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_BIN   = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_STRIPS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } t_back_state;

    // word passed from front to back
    typedef struct packed {
        t_op                 op;
        logic [PRIM_W-1:0]   prim;
        logic [COORD_W-1:0]  x_min;
        logic [COORD_W-1:0]  x_max;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [SID_W-1:0]    strip_id;
        logic [SLOT_W-1:0]   slot;
        logic [PRIM_W-1:0]   prim;
        logic                last;
    } t_res;

endpackage

[rtl/core/ssb_fifo.sv]
// small register queue used between the binner stages
module ssb_fifo
    import ssb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointer wrap
    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= next_ptr(r_wp);
            end
            if (rd_en) begin
                r_rp <= next_ptr(r_rp);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/core/ssb_span_div.sv]
// restoring divider that derives the strip width from the window width
module ssb_span_div
    import ssb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SIZE_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [SIZE_W-1:0] o_quot
);

    logic [CNT_W-1:0]  r_rem;
    logic [SIZE_W-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // one trial subtraction per cycle
    assign trial = {r_rem, r_quo[SIZE_W-1]};
    assign ge    = (trial >= {1'b0, i_divisor});
    assign diff  = trial - {1'b0, i_divisor};

    assign o_busy = (r_cnt != '0) || i_start;
    assign o_quot = r_quo;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CW'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[SIZE_W-2:0], ge};
        end
    end

endmodule

[rtl/core/ssb_front.sv]
// front end: accepts words, culls off-screen boxes, queues the rest
module ssb_front
    import ssb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_op,
    input  logic [PRIM_W-1:0]         i_prim_index,
    input  logic signed [COORD_W-1:0] i_box_x_min,
    input  logic signed [COORD_W-1:0] i_box_x_max,
    input  logic signed [COORD_W-1:0] i_box_y_min,
    input  logic signed [COORD_W-1:0] i_box_y_max,
    input  logic [SIZE_W-1:0]         i_width,
    input  logic [SIZE_W-1:0]         i_height,
    input  logic                      i_hold,
    output logic                      o_full,
    input  logic                      i_cmd_pop,
    output t_cmd                      o_cmd,
    output logic                      o_cmd_empty
);

    logic signed [COORD_W:0] w_ext;
    logic signed [COORD_W:0] h_ext;
    logic signed [COORD_W:0] xmin_ext;
    logic signed [COORD_W:0] ymin_ext;
    logic                    culled;
    logic                    accept;
    logic                    q_push;
    logic                    q_full;
    t_cmd                    cmd_in;

    // off-screen test against the window bounds
    assign w_ext    = $signed({{(COORD_W + 1 - SIZE_W){1'b0}}, i_width});
    assign h_ext    = $signed({{(COORD_W + 1 - SIZE_W){1'b0}}, i_height});
    assign xmin_ext = {i_box_x_min[COORD_W-1], i_box_x_min};
    assign ymin_ext = {i_box_y_min[COORD_W-1], i_box_y_min};
    assign culled   = i_box_x_max[COORD_W-1] || (xmin_ext >= w_ext) ||
                      i_box_y_max[COORD_W-1] || (ymin_ext >= h_ext);

    // accept and enqueue; culled primitives are consumed here
    assign o_full = q_full || i_hold;
    assign accept = i_push && !o_full;
    assign q_push = accept && ((t_op'(i_op) == OP_FRAME) || !culled);

    always_comb begin
        cmd_in.op    = t_op'(i_op);
        cmd_in.prim  = i_prim_index;
        cmd_in.x_min = i_box_x_min;
        cmd_in.x_max = i_box_x_max;
    end

    ssb_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cmd_in),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (q_full),
        .o_empty (o_cmd_empty)
    );

endmodule

[rtl/core/ssb_back.sv]
// back end: walks the strips, keeps fill counts, emits result words
module ssb_back
    import ssb_pkg::*;
#(
    parameter int STRIP_SLOTS  = 16,
    parameter int BUCKET_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic [SIZE_W-1:0] i_span,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [CNT_W-1:0]  i_nstrips,
    input  logic              i_res_full,
    output logic              o_res_push,
    output t_res              o_res
);

    localparam int IW = (STRIP_SLOTS > 1) ? $clog2(STRIP_SLOTS) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);

    t_back_state              r_state;
    t_back_state              n_state;
    logic [FW-1:0]            r_fill [STRIP_SLOTS];
    logic [FW-1:0]            n_fill [STRIP_SLOTS];
    logic [CNT_W-1:0]         r_s;
    logic [CNT_W-1:0]         n_s;
    logic [SIZE_W-1:0]        r_start;
    logic [SIZE_W-1:0]        n_start;
    logic [PRIM_W-1:0]        r_prim;
    logic [PRIM_W-1:0]        n_prim;
    logic [COORD_W-1:0]       r_xmin;
    logic [COORD_W-1:0]       n_xmin;
    logic [COORD_W-1:0]       r_xmax;
    logic [COORD_W-1:0]       n_xmax;
    logic                     r_pend_v;
    logic                     n_pend_v;
    logic [SID_W-1:0]         r_pend_id;
    logic [SID_W-1:0]         n_pend_id;
    logic [SLOT_W-1:0]        r_pend_slot;
    logic [SLOT_W-1:0]        n_pend_slot;

    logic [IW-1:0]            idx;
    logic                     last_strip;
    logic [SIZE_W:0]          end_sum;
    logic [SIZE_W:0]          end_val;
    logic signed [COORD_W:0]  start_ext;
    logic signed [COORD_W:0]  end_ext;
    logic signed [COORD_W:0]  xmin_ext;
    logic signed [COORD_W:0]  xmax_ext;
    logic                     room;
    logic                     hit;
    logic                     done;

    // bounds of the strip under test
    assign idx        = r_s[IW-1:0];
    assign last_strip = (r_s == i_nstrips - 1'b1);
    assign end_sum    = {1'b0, r_start} + {1'b0, i_span};
    assign end_val    = last_strip ? {1'b0, i_width} : end_sum;
    assign start_ext  = $signed({{(COORD_W + 1 - SIZE_W){1'b0}}, r_start});
    assign end_ext    = $signed({{(COORD_W - SIZE_W){1'b0}}, end_val});
    assign xmin_ext   = {r_xmin[COORD_W-1], r_xmin};
    assign xmax_ext   = {r_xmax[COORD_W-1], r_xmax};

    // overlap, bucket space, and whether any later strip can still overlap
    assign room = (r_fill[idx] < FW'(BUCKET_DEPTH));
    assign hit  = (xmin_ext < end_ext) && (xmax_ext > start_ext) && room;
    assign done = last_strip || (xmax_ext <= end_ext);

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_pend_v <= 1'b0;
            for (int i = 0; i < STRIP_SLOTS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_start     <= n_start;
        r_prim      <= n_prim;
        r_xmin      <= n_xmin;
        r_xmax      <= n_xmax;
        r_pend_id   <= n_pend_id;
        r_pend_slot <= n_pend_slot;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_s         = r_s;
        n_start     = r_start;
        n_prim      = r_prim;
        n_xmin      = r_xmin;
        n_xmax      = r_xmax;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        n_pend_slot = r_pend_slot;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res.strip_id = r_pend_id;
        o_res.slot     = r_pend_slot;
        o_res.prim     = r_prim;
        o_res.last     = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_FRAME) begin
                        for (int i = 0; i < STRIP_SLOTS; i++) begin
                            n_fill[i] = '0;
                        end
                    end else begin
                        n_prim   = i_cmd.prim;
                        n_xmin   = i_cmd.x_min;
                        n_xmax   = i_cmd.x_max;
                        n_s      = '0;
                        n_start  = '0;
                        n_pend_v = 1'b0;
                        n_state  = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                // a new hit pushes out the held one; stall if the queue is full
                if (!(hit && r_pend_v && i_res_full)) begin
                    o_res_push = hit && r_pend_v;
                    if (hit) begin
                        n_pend_v    = 1'b1;
                        n_pend_id   = r_s[SID_W-1:0];
                        n_pend_slot = SLOT_W'(r_fill[idx]);
                        n_fill[idx] = r_fill[idx] + 1'b1;
                    end
                    n_s     = r_s + 1'b1;
                    n_start = end_val[SIZE_W-1:0];
                    if (done) begin
                        n_state = (r_pend_v || hit) ? BK_FLUSH : BK_IDLE;
                    end
                end
            end
            BK_FLUSH: begin
                // held result is the last one of the primitive
                o_res.last = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // never write into a full result queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    // flushing always has a held result
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FLUSH) |-> r_pend_v)
        else $error("flush without held result");

    // frame start empties the buckets; checked on bucket 0
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && !i_cmd_empty && i_cmd.op == OP_FRAME)
        |=> (r_fill[0] == '0))
        else $error("fill count not cleared on frame start");

    // scan index stays inside the active strips
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SCAN) |-> (r_s < i_nstrips))
        else $error("strip index past active strips");

endmodule

[rtl/core/screen_strip_binner.sv]
// top level of the screen strip binner: registers, span divider, front and back
// Splits the window into up to 16 vertical strips, each as wide as the window width
// divided by the strip count (the last strip runs to the right window edge) and,
// for each accepted primitive whose box lies on screen, emits one result word per
// overlapping strip whose bucket is not full, in ascending strip order, with
// run_last set on the final one; a frame-start word zeroes all fill counts and
// gives no result. The front end takes one word per cycle while full is low and
// drops off-screen primitives at once; the back end takes a word in its idle state,
// then walks strips from strip 0, one strip per cycle unless a full result queue
// stalls it, stopping at the first strip whose right end reaches the box's x_max
// (or at the last strip), then, if any strip was hit, pushes the final result from
// a flush state, and only then returns to idle for the next word. After reset and
// after each write to a known register the strip width is recomputed by a bit-serial
// divider, during which full stays high.
module screen_strip_binner
    import ssb_pkg::*;
#(
    parameter int MAX_STRIPS   = 16,
    parameter int BUCKET_DEPTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input queue side
    input  logic                      push,
    output logic                      full,
    input  logic                      i_op,
    input  logic [PRIM_W-1:0]         i_prim_index,
    input  logic signed [COORD_W-1:0] i_box_x_min,
    input  logic signed [COORD_W-1:0] i_box_x_max,
    input  logic signed [COORD_W-1:0] i_box_y_min,
    input  logic signed [COORD_W-1:0] i_box_y_max,
    // result queue side
    output logic                      empty,
    input  logic                      pop,
    output logic [SID_W-1:0]          o_strip_id,
    output logic [SLOT_W-1:0]         o_bucket_slot,
    output logic [PRIM_W-1:0]         o_binned_prim,
    output logic                      o_run_last,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CIDX_W-1:0]         i_cfg_index,
    input  logic [SIZE_W-1:0]         i_cfg_data
);

    localparam int STRIP_SLOTS = (MAX_STRIPS < ID_LIMIT) ? MAX_STRIPS : ID_LIMIT;

    logic [CNT_W-1:0]  r_strips;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              r_recalc;
    logic [CNT_W-1:0]  nstrips;
    logic              div_busy;
    logic [SIZE_W-1:0] span;
    logic              cfg_wr;
    t_cmd              cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_push;
    logic              res_full;
    t_res              res_in;
    t_res              res_out;

    // configuration registers; a write to a known register restarts the span divider
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strips <= CNT_W'(4);
            r_width  <= SIZE_W'(640);
            r_height <= SIZE_W'(480);
            r_recalc <= 1'b1;
        end else begin
            r_recalc <= cfg_wr && (t_cfg_idx'(i_cfg_index) != CFG_UNUSED);
            if (cfg_wr) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STRIPS: begin
                        r_strips <= i_cfg_data[CNT_W-1:0];
                    end
                    CFG_WIDTH: begin
                        r_width <= i_cfg_data;
                    end
                    CFG_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // active strip count: zero means one, clamp to the strip limit
    always_comb begin
        if (r_strips == '0) begin
            nstrips = CNT_W'(1);
        end else if (r_strips > CNT_W'(STRIP_SLOTS)) begin
            nstrips = CNT_W'(STRIP_SLOTS);
        end else begin
            nstrips = r_strips;
        end
    end

    // strip width
    ssb_span_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc),
        .i_dividend (r_width),
        .i_divisor  (nstrips),
        .o_busy     (div_busy),
        .o_quot     (span)
    );

    // front end with command queue
    ssb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_op         (i_op),
        .i_prim_index (i_prim_index),
        .i_box_x_min  (i_box_x_min),
        .i_box_x_max  (i_box_x_max),
        .i_box_y_min  (i_box_y_min),
        .i_box_y_max  (i_box_y_max),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_hold       (div_busy),
        .o_full       (full),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd),
        .o_cmd_empty  (cmd_empty)
    );

    // back end strip walker
    ssb_back #(
        .STRIP_SLOTS  (STRIP_SLOTS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_span      (span),
        .i_width     (r_width),
        .i_nstrips   (nstrips),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue
    ssb_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_strip_id    = res_out.strip_id;
    assign o_bucket_slot = res_out.slot;
    assign o_binned_prim = res_out.prim;
    assign o_run_last    = res_out.last;

endmodule

[bench/screen_strip_binner_test.sv]
// self-checking testbench for the screen strip binner
`timescale 1ns / 100ps

module screen_strip_binner_test;
    import ssb_pkg::*;

    localparam int STRIP_MAX    = 16;
    localparam int DEPTH        = 4096;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 3000000;

    // one primitive or frame-start word as pushed into the block
    typedef struct {
        t_op                      op;
        logic [PRIM_W-1:0]        prim;
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_max;
    } t_prim_word;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic                      i_op;
    logic [PRIM_W-1:0]         i_prim_index;
    logic signed [COORD_W-1:0] i_box_x_min;
    logic signed [COORD_W-1:0] i_box_x_max;
    logic signed [COORD_W-1:0] i_box_y_min;
    logic signed [COORD_W-1:0] i_box_y_max;
    logic                      empty;
    logic                      pop;
    logic [SID_W-1:0]          o_strip_id;
    logic [SLOT_W-1:0]         o_bucket_slot;
    logic [PRIM_W-1:0]         o_binned_prim;
    logic                      o_run_last;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CIDX_W-1:0]         i_cfg_index;
    logic [SIZE_W-1:0]         i_cfg_data;

    // shadow copy of the block's registers and strip state
    logic [CNT_W-1:0]  shadow_strips;
    logic [SIZE_W-1:0] shadow_width;
    logic [SIZE_W-1:0] shadow_height;
    int                strip_span;
    int                strip_fill [STRIP_MAX];

    t_prim_word pending_words [$];
    t_res       strip_entry_q [$];
    t_prim_word drv_word;
    bit         drv_busy;
    int         push_hold;
    int         pop_hold;
    bit         in_idle_on;
    bit         out_idle_on;
    int         words_queued;
    int         words_accepted;
    int         entries_checked;
    int         cfg_writes;
    int         error_count;
    int         cycle_count;

    screen_strip_binner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_prim_index  (i_prim_index),
        .i_box_x_min   (i_box_x_min),
        .i_box_x_max   (i_box_x_max),
        .i_box_y_min   (i_box_y_min),
        .i_box_y_max   (i_box_y_max),
        .empty         (empty),
        .pop           (pop),
        .o_strip_id    (o_strip_id),
        .o_bucket_slot (o_bucket_slot),
        .o_binned_prim (o_binned_prim),
        .o_run_last    (o_run_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // strip count after the zero and saturation rules
    function automatic int strips_in_use();
        int n;
        n = shadow_strips;
        if (n == 0) n = 1;
        if (n > STRIP_MAX) n = STRIP_MAX;
        return n;
    endfunction

    // register write as seen by the shadow state
    function automatic void cfg_apply(t_cfg_idx idx, logic [SIZE_W-1:0] data);
        case (idx)
            CFG_STRIPS: begin
                shadow_strips = data[CNT_W-1:0];
            end
            CFG_WIDTH: begin
                shadow_width = data;
            end
            CFG_HEIGHT: begin
                shadow_height = data;
            end
            default: begin
                return;
            end
        endcase
        strip_span = int'(shadow_width) / strips_in_use();
    endfunction

    // expected strip entries for one accepted word
    function automatic void bin_predict(t_prim_word wd);
        int   n, s, start, stop, w, h;
        int   xmin, xmax, ymin, ymax;
        t_res r;
        t_res run_q [$];
        if (wd.op == OP_FRAME) begin
            foreach (strip_fill[k]) strip_fill[k] = 0;
            return;
        end
        xmin = int'(wd.x_min);
        xmax = int'(wd.x_max);
        ymin = int'(wd.y_min);
        ymax = int'(wd.y_max);
        w = int'(shadow_width);
        h = int'(shadow_height);
        // off-screen cull
        if (xmax < 0 || xmin >= w || ymax < 0 || ymin >= h) return;
        n = strips_in_use();
        for (s = 0; s < n; s++) begin
            start = s * strip_span;
            stop  = (s == n - 1) ? w : (s + 1) * strip_span;
            if (xmin < stop && xmax > start && strip_fill[s] < DEPTH) begin
                r.strip_id = s[SID_W-1:0];
                r.slot     = strip_fill[s][SLOT_W-1:0];
                r.prim     = wd.prim;
                r.last     = 1'b0;
                run_q.push_back(r);
                strip_fill[s]++;
            end
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[k]) strip_entry_q.push_back(run_q[k]);
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int idle_len(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // uniform pick in [lo, hi]
    function automatic int pick(int lo, int hi);
        if (hi <= lo) return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // input side: accept at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            bin_predict(drv_word);
            words_accepted++;
            drv_busy = 1'b0;
            push_hold = idle_len(in_idle_on);
        end
    end

    // input side: drive the next word at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!drv_busy) begin
            if (push_hold > 0) begin
                push <= 1'b0;
                push_hold--;
            end else if (pending_words.size() > 0) begin
                drv_word = pending_words.pop_front();
                i_op         <= drv_word.op;
                i_prim_index <= drv_word.prim;
                i_box_x_min  <= drv_word.x_min;
                i_box_x_max  <= drv_word.x_max;
                i_box_y_min  <= drv_word.y_min;
                i_box_y_max  <= drv_word.y_max;
                push <= 1'b1;
                drv_busy = 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: check each popped word against the oldest expectation
    always @(posedge i_clk) begin
        t_res exp_w;
        if (i_rst_n && pop && !empty) begin
            if (strip_entry_q.size() == 0) begin
                $display("%0t unexpected word: strip %0d slot %0d prim %0d last %0b",
                         $time, o_strip_id, o_bucket_slot, o_binned_prim, o_run_last);
                error_count++;
            end else begin
                exp_w = strip_entry_q.pop_front();
                if (exp_w.strip_id !== o_strip_id || exp_w.slot !== o_bucket_slot ||
                    exp_w.prim !== o_binned_prim || exp_w.last !== o_run_last) begin
                    $display("%0t mismatch: expected strip %0d slot %0d prim %0d last %0b",
                             $time, exp_w.strip_id, exp_w.slot, exp_w.prim, exp_w.last);
                    $display("%0t           actual   strip %0d slot %0d prim %0d last %0b",
                             $time, o_strip_id, o_bucket_slot, o_binned_prim, o_run_last);
                    error_count++;
                end
            end
            entries_checked++;
            pop_hold = idle_len(out_idle_on);
        end
    end

    // result side: pop with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic queue_box(t_op op, int prim, int x0, int x1, int y0, int y1);
        t_prim_word wd;
        wd.op    = op;
        wd.prim  = prim[PRIM_W-1:0];
        wd.x_min = x0[COORD_W-1:0];
        wd.x_max = x1[COORD_W-1:0];
        wd.y_min = y0[COORD_W-1:0];
        wd.y_max = y1[COORD_W-1:0];
        pending_words.push_back(wd);
        words_queued++;
    endtask

    // random words shaped around the current window
    task automatic queue_random_boxes(int count);
        int r, w, h, x0, x1, y0, y1, t;
        w = int'(shadow_width);
        h = int'(shadow_height);
        repeat (count) begin
            r  = $urandom_range(0, 99);
            x0 = pick(-20, w + 4);
            x1 = ($urandom_range(0, 1) == 1) ? x0 + pick(0, strip_span + 2)
                                             : x0 + pick(0, w / 2 + 8);
            y0 = pick(-10, h + 4);
            y1 = y0 + pick(0, h / 2 + 4);
            if (r < 5) begin
                queue_box(OP_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 75) begin
                queue_box(OP_BIN, $urandom, x0, x1, y0, y1);
            end else if (r < 85) begin
                // inverted box
                queue_box(OP_BIN, $urandom, x1, x0, y1, y0);
            end else if (r < 92) begin
                // wholly off one side
                t = $urandom_range(0, 3);
                case (t)
                    0: queue_box(OP_BIN, $urandom, pick(-32768, -2), -1, y0, y1);
                    1: queue_box(OP_BIN, $urandom, w, pick(w, 32767), y0, y1);
                    2: queue_box(OP_BIN, $urandom, x0, x1, pick(-32768, -2), -1);
                    default: queue_box(OP_BIN, $urandom, x0, x1, h, pick(h, 32767));
                endcase
            end else begin
                queue_box(OP_BIN, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // wait until every word is in and every entry is out, then let the block settle
    task automatic drain();
        while (words_accepted != words_queued || strip_entry_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [SIZE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_apply(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(int strips, int width, int height);
        cfg_write(CFG_STRIPS, strips[SIZE_W-1:0]);
        cfg_write(CFG_WIDTH, width[SIZE_W-1:0]);
        cfg_write(CFG_HEIGHT, height[SIZE_W-1:0]);
    endtask

    // stimulus sequence
    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_op         = OP_FRAME;
        i_prim_index = '0;
        i_box_x_min  = '0;
        i_box_x_max  = '0;
        i_box_y_min  = '0;
        i_box_y_max  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_STRIPS;
        i_cfg_data   = '0;
        drv_busy     = 1'b0;
        push_hold    = 0;
        pop_hold     = 0;
        in_idle_on   = 1'b1;
        out_idle_on  = 1'b1;
        words_queued = 0;
        words_accepted  = 0;
        entries_checked = 0;
        cfg_writes   = 0;
        error_count  = 0;
        cycle_count  = 0;
        shadow_strips = 5'd4;
        shadow_width  = 13'd640;
        shadow_height = 13'd480;
        foreach (strip_fill[k]) strip_fill[k] = 0;
        strip_span = 640 / 4;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at the reset settings: 4 strips of 160 over 640 x 480
        queue_box(OP_FRAME, 0, 0, 0, 0, 0);
        queue_box(OP_BIN, 1, 10, 20, 10, 20);
        queue_box(OP_BIN, 2, -100, 1000, 0, 479);
        queue_box(OP_BIN, 3, 159, 160, 5, 6);
        queue_box(OP_BIN, 4, 160, 160, 5, 6);
        queue_box(OP_BIN, 5, 0, 0, 0, 0);
        queue_box(OP_BIN, 6, 639, 639, 479, 479);
        queue_box(OP_BIN, 7, -50, -1, 0, 100);
        queue_box(OP_BIN, 8, 640, 700, 0, 100);
        queue_box(OP_BIN, 9, 0, 100, -50, -1);
        queue_box(OP_BIN, 10, 0, 100, 480, 600);
        queue_box(OP_BIN, 11, 500, 100, 0, 10);
        queue_box(OP_BIN, 12, 300, 200, 10, 0);
        queue_box(OP_BIN, 0, -32768, 32767, -32768, 32767);
        queue_box(OP_BIN, 65535, 32767, -32768, 32767, -32768);
        queue_box(OP_FRAME, 65535, -1, -1, -1, -1);
        queue_box(OP_BIN, 13, 320, 481, 0, 479);
        drain();

        // random phases across register settings, extremes first
        cfg_all(1, 1, 1);
        queue_random_boxes(40);
        drain();
        cfg_all(16, 4096, 4096);
        queue_random_boxes(40);
        drain();
        cfg_all(0, 100, 100);
        cfg_write(CFG_UNUSED, SIZE_W'($urandom));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        queue_random_boxes(40);
        drain();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        cfg_all(13'h1FFF, 13'h1FFF, 0);
        queue_random_boxes(40);
        drain();
        cfg_all(17, 0, 4096);
        queue_random_boxes(40);
        drain();
        cfg_all(7, 1000, 300);
        queue_random_boxes(40);
        drain();
        cfg_all($urandom_range(0, 31), $urandom_range(0, 8191), $urandom_range(0, 8191));
        queue_random_boxes(40);
        drain();

        // fill counts climb within a frame and restart after a frame start
        cfg_all(2, 64, 64);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        queue_box(OP_FRAME, 0, 0, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            queue_box(OP_BIN, i, 0, 63, 0, 63);
        queue_box(OP_BIN, 1, 0, 10, 0, 10);
        queue_box(OP_FRAME, 0, 0, 0, 0, 0);
        queue_box(OP_BIN, 2, 0, 63, 0, 63);
        drain();

        $display("ran %0d words in, %0d strip entries checked, %0d register writes",
                 words_accepted, entries_checked, cfg_writes);
        $display("covered zero and saturated strip counts, zero and full windows, frame clears");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d errors", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ssb_pkg.sv
rtl/core/ssb_fifo.sv
rtl/core/ssb_span_div.sv
rtl/core/ssb_front.sv
rtl/core/ssb_back.sv
rtl/core/screen_strip_binner.sv
bench/screen_strip_binner_test.sv
